### src/apma_pkg.sv
// ----------------------------------------------------------------------------
// apma_pkg
// Shared widths, reset value and control types of the peak moving average.
// ----------------------------------------------------------------------------
package apma_pkg;

  localparam int ACCEL_W            = 16;  // raw sample width, two's complement
  localparam int PEAK_W             = 16;  // peak magnitude width
  localparam int OFFSET_W           = 15;  // gravity offset register width
  localparam int SUM_W              = 22;  // running sum width (64 * 65535 < 2^22)
  localparam int AVG_W              = 16;  // average result width
  localparam int WINDOW_LEN_DEFAULT = 50;

  localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(16384);

  // Requests from the pipeline to the window store
  typedef struct packed {
    logic              rd_en;    // transaction accepted: fetch the oldest entry
    logic              wr_en;    // item leaves the input stage: replace the entry
    logic [PEAK_W-1:0] wr_peak;  // peak of that item
  } win_ctrl_t;

endpackage

### src/apma_ifs.sv
// ----------------------------------------------------------------------------
// apma_ifs
// Valid/ready channels of the peak moving average: samples, results, offset.
// ----------------------------------------------------------------------------
interface apma_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [apma_pkg::ACCEL_W-1:0] accel_x;
  logic signed [apma_pkg::ACCEL_W-1:0] accel_y;
  logic signed [apma_pkg::ACCEL_W-1:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z,
                  input ready);
  modport sink (input valid, input accel_x, input accel_y, input accel_z,
                output ready);
endinterface

interface apma_out_if;
  logic                        valid;
  logic                        ready;
  logic [apma_pkg::AVG_W-1:0]  window_average;
  logic [apma_pkg::PEAK_W-1:0] sample_peak;

  modport source (output valid, output window_average, output sample_peak,
                  input ready);
  modport sink (input valid, input window_average, input sample_peak,
                output ready);
endinterface

interface apma_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [apma_pkg::OFFSET_W-1:0] gravity_offset;

  modport source (output valid, output gravity_offset, input ready);
  modport sink (input valid, input gravity_offset, output ready);
endinterface

### src/accel_peak_moving_average.sv
// ----------------------------------------------------------------------------
// accel_peak_moving_average
// Boxcar average of per-sample peak acceleration magnitude.
// ----------------------------------------------------------------------------
// Each transaction on in_bus carries one raw three-axis sample (16384 counts
// per g). The Z axis has gravity_offset taken off, every axis is reduced to
// its magnitude and the largest becomes the sample peak. Peaks enter a ring
// window of WINDOW_LEN entries; each sample yields one result on out_bus with
// the peak and the window sum divided by WINDOW_LEN, truncated. Until the
// window has filled, unwritten entries count as zero and the divisor stays
// WINDOW_LEN. The block takes one sample per clock and gives one result per
// clock while out_bus is ready. A sample passes the input stage (which
// registers it and starts the store read), the peak and sum stage and the
// result register that holds the divided result. No clearing pass follows
// reset: per-entry valid bits clear the store at once.
// gravity_offset is written on cfg_bus (always ready) and resets to 16384;
// write it only while no sample is in flight.
// ----------------------------------------------------------------------------
module accel_peak_moving_average #(
  parameter int WINDOW_LEN = apma_pkg::WINDOW_LEN_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  apma_in_if.sink     in_bus,
  apma_out_if.source  out_bus,
  apma_cfg_if.sink    cfg_bus
);

  // floor(n / WINDOW_LEN) = (n * DIV_RECIP) >> DIV_SHIFT for any n below 2^SUM_W
  localparam int DIV_SHIFT = apma_pkg::SUM_W + $clog2(WINDOW_LEN);
  localparam int RECIP_W   = apma_pkg::SUM_W + 1;
  localparam int PROD_W    = apma_pkg::SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

  logic [apma_pkg::OFFSET_W-1:0] offset_r;

  // input stage
  logic                                s1_vld_r;
  logic signed [apma_pkg::ACCEL_W-1:0] s1_x_r;
  logic signed [apma_pkg::ACCEL_W-1:0] s1_y_r;
  logic signed [apma_pkg::ACCEL_W-1:0] s1_z_r;
  // peak stage
  logic                                s2_vld_r;
  logic        [apma_pkg::PEAK_W-1:0]  s2_peak_r;
  // result register
  logic                                out_vld_r;
  logic        [apma_pkg::AVG_W-1:0]   out_avg_r;
  logic        [apma_pkg::PEAK_W-1:0]  out_peak_r;

  logic                                in_fire;
  logic                                s1_adv;
  logic                                s2_adv;
  logic        [apma_pkg::PEAK_W-1:0]  s1_peak;
  logic        [apma_pkg::SUM_W-1:0]   window_sum;
  logic        [PROD_W-1:0]            avg_prod;
  apma_pkg::win_ctrl_t                 win_ctrl;

  // advance each stage when the next one is empty or moving on
  assign s2_adv       = s2_vld_r && (!out_vld_r || out_bus.ready);
  assign s1_adv       = s1_vld_r && (!s2_vld_r || s2_adv);
  assign in_bus.ready = !s1_vld_r || s1_adv;
  assign in_fire      = in_bus.valid && in_bus.ready;

  assign cfg_bus.ready = 1'b1;

  apma_peak u_peak (
    .accel_x        (s1_x_r),
    .accel_y        (s1_y_r),
    .accel_z        (s1_z_r),
    .gravity_offset (offset_r),
    .peak           (s1_peak)
  );

  // fetch the oldest entry on acceptance; replace it as the item leaves stage 1
  assign win_ctrl.rd_en   = in_fire;
  assign win_ctrl.wr_en   = s1_adv;
  assign win_ctrl.wr_peak = s1_peak;

  apma_window #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (win_ctrl),
    .window_sum (window_sum)
  );

  // window_sum already includes the item held in stage 2
  assign avg_prod = PROD_W'(window_sum) * PROD_W'(DIV_RECIP);

  // payload registers: hold unless the stage advances
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_x_r <= in_bus.accel_x;
      s1_y_r <= in_bus.accel_y;
      s1_z_r <= in_bus.accel_z;
    end
    if (s1_adv) begin
      s2_peak_r <= s1_peak;
    end
    if (s2_adv) begin
      out_avg_r  <= apma_pkg::AVG_W'(avg_prod >> DIV_SHIFT);
      out_peak_r <= s2_peak_r;
    end
  end

  // control state and the offset register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r  <= apma_pkg::OFFSET_RESET;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_bus.valid) begin
        offset_r <= cfg_bus.gravity_offset;
      end
      if (in_bus.ready) begin
        s1_vld_r <= in_bus.valid;
      end
      if (!s2_vld_r || s2_adv) begin
        s2_vld_r <= s1_vld_r;
      end
      if (!out_vld_r || out_bus.ready) begin
        out_vld_r <= s2_vld_r;
      end
    end
  end

  assign out_bus.valid          = out_vld_r;
  assign out_bus.window_average = out_avg_r;
  assign out_bus.sample_peak    = out_peak_r;

`ifndef ASSERT_OFF
  a_s1_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && s1_vld_r |-> s1_adv)
    else $error("input stage overwritten while occupied");

  a_s2_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s2_vld_r |-> s2_adv)
    else $error("peak stage overwritten while occupied");

  a_out_from_s2 : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(s2_vld_r))
    else $error("result raised without an item in the peak stage");
`endif

endmodule

### src/apma_peak.sv
// ----------------------------------------------------------------------------
// apma_peak
// Largest absolute axis value of one sample, gravity offset taken off Z.
// ----------------------------------------------------------------------------
module apma_peak (
  input  logic signed [apma_pkg::ACCEL_W-1:0]  accel_x,
  input  logic signed [apma_pkg::ACCEL_W-1:0]  accel_y,
  input  logic signed [apma_pkg::ACCEL_W-1:0]  accel_z,
  input  logic        [apma_pkg::OFFSET_W-1:0] gravity_offset,
  output logic        [apma_pkg::PEAK_W-1:0]   peak
);

  localparam int ZW = apma_pkg::ACCEL_W + 1;

  logic signed [ZW-1:0]               z_adj;
  logic        [apma_pkg::PEAK_W-1:0] mag_x;
  logic        [apma_pkg::PEAK_W-1:0] mag_y;
  logic        [apma_pkg::PEAK_W-1:0] mag_z;
  logic        [apma_pkg::PEAK_W-1:0] max_xy;

  // z - offset lies in [-65535, 32767]: 17 bits signed
  assign z_adj = ZW'(accel_z) - $signed({2'b00, gravity_offset});

  // magnitudes fit 16 bits unsigned (|-32768| = 32768, |-65535| = 65535)
  assign mag_x = accel_x[apma_pkg::ACCEL_W-1] ? apma_pkg::PEAK_W'(-accel_x)
                                              : apma_pkg::PEAK_W'(accel_x);
  assign mag_y = accel_y[apma_pkg::ACCEL_W-1] ? apma_pkg::PEAK_W'(-accel_y)
                                              : apma_pkg::PEAK_W'(accel_y);
  assign mag_z = z_adj[ZW-1] ? apma_pkg::PEAK_W'(-z_adj)
                             : apma_pkg::PEAK_W'(z_adj);

  assign max_xy = (mag_x > mag_y) ? mag_x : mag_y;
  assign peak   = (mag_z > max_xy) ? mag_z : max_xy;

endmodule

### src/apma_window.sv
// ----------------------------------------------------------------------------
// apma_window
// Ring store of recent peaks with per-entry valid bits and the running sum.
// ----------------------------------------------------------------------------
module apma_window #(
  parameter int WINDOW_LEN = apma_pkg::WINDOW_LEN_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  apma_pkg::win_ctrl_t            ctrl,
  output logic [apma_pkg::SUM_W-1:0]     window_sum
);

  localparam int SLOT_W = $clog2(WINDOW_LEN);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LEN - 1);
  localparam logic [apma_pkg::SUM_W-1:0] SUM_MAX =
    apma_pkg::SUM_W'(WINDOW_LEN * ((1 << apma_pkg::PEAK_W) - 1));

  logic [apma_pkg::PEAK_W-1:0] win_mem [WINDOW_LEN];
  logic [WINDOW_LEN-1:0]       ent_vld_r;
  logic [SLOT_W-1:0]           write_slot_r;
  logic [SLOT_W-1:0]           wr_slot_r;
  logic [apma_pkg::PEAK_W-1:0] rd_data_r;
  logic                        rd_vld_r;
  logic [apma_pkg::SUM_W-1:0]  sum_r;
  logic [apma_pkg::SUM_W-1:0]  sum_nxt;
  logic [apma_pkg::PEAK_W-1:0] old_peak;

  // an entry never written counts as zero
  assign old_peak = rd_vld_r ? rd_data_r : '0;
  assign sum_nxt  = sum_r - apma_pkg::SUM_W'(old_peak) + apma_pkg::SUM_W'(ctrl.wr_peak);

  // storage: one read and one write port, registered read data
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data_r <= win_mem[write_slot_r];
    end
    if (ctrl.wr_en) begin
      win_mem[wr_slot_r] <= ctrl.wr_peak;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r    <= '0;
      write_slot_r <= '0;
      wr_slot_r    <= '0;
      rd_vld_r     <= 1'b0;
      sum_r        <= '0;
    end else begin
      if (ctrl.rd_en) begin
        rd_vld_r     <= ent_vld_r[write_slot_r];
        wr_slot_r    <= write_slot_r;
        write_slot_r <= (write_slot_r == LAST_SLOT) ? '0 : write_slot_r + 1'b1;
      end
      if (ctrl.wr_en) begin
        ent_vld_r[wr_slot_r] <= 1'b1;
        sum_r                <= sum_nxt;
      end
    end
  end

  assign window_sum = sum_r;

`ifndef ASSERT_OFF
  a_slot_range : assert property (@(posedge clk) disable iff (!rst_n)
    write_slot_r <= LAST_SLOT)
    else $error("write slot beyond window");

  a_sum_bound : assert property (@(posedge clk) disable iff (!rst_n)
    sum_r <= SUM_MAX)
    else $error("running sum exceeds window maximum");

  a_wr_after_rd : assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.wr_en && !ctrl.rd_en |=> !ctrl.wr_en)
    else $error("store written twice for one fetched entry");
`endif

endmodule

### tb/accel_peak_moving_average_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// accel_peak_moving_average_tb
// Self-checking bench for the peak-magnitude boxcar average.
// ----------------------------------------------------------------------------
// Drive raw three-axis samples into the block and keep a model of the peak
// window alongside it. Each sample transaction updates the model and queues
// the result it should give. Compare each result transaction with the oldest
// queued entry. Cover axis extremes, both ends of the gravity offset, a window
// held at full scale across wrap-around, then random traffic under several
// idle and back-pressure patterns.
// ----------------------------------------------------------------------------
module accel_peak_moving_average_tb;

  localparam int WINDOW_LEN     = apma_pkg::WINDOW_LEN_DEFAULT;
  // Cycles with no transaction on any channel before the run is abandoned.
  // The longest legal quiet stretch is a long run of sender idles or receiver
  // stalls at 86 %, which stays far below this.
  localparam int STALL_LIMIT    = 4000;
  // Input stage, peak and sum stage, divide stage.
  localparam int PIPE_LATENCY   = 3;

  typedef struct {
    logic [apma_pkg::AVG_W-1:0]  window_average;
    logic [apma_pkg::PEAK_W-1:0] sample_peak;
  } window_result_t;

  logic clk;
  logic rst_n;

  apma_in_if  in_if ();
  apma_out_if out_if ();
  apma_cfg_if cfg_if ();

  accel_peak_moving_average #(
    .WINDOW_LEN (WINDOW_LEN)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if),
    .cfg_bus (cfg_if)
  );

  // Model state: the window of peaks, the next slot to replace, the running
  // sum and the gravity offset currently in force.
  logic [apma_pkg::PEAK_W-1:0]   peak_store [WINDOW_LEN];
  int                            next_slot;
  logic [apma_pkg::SUM_W-1:0]    running_sum;
  logic [apma_pkg::OFFSET_W-1:0] offset_model;

  window_result_t pending_results [$];
  int             fail_count;

  // Idle and stall rates in percent, changed per traffic phase.
  int send_idle_pct;
  int recv_stall_pct;

  // ------------------------------------------------------------------------
  // Clock
  // ------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // Window model
  // ------------------------------------------------------------------------
  // Take the offset off Z, reduce every axis to its magnitude and keep the
  // largest. Replace the oldest entry and move the running sum by the
  // difference. Unwritten entries are zero, so the divisor is always the
  // full window length even while the window fills.
  function automatic window_result_t advance_window(
    logic signed [apma_pkg::ACCEL_W-1:0] x,
    logic signed [apma_pkg::ACCEL_W-1:0] y,
    logic signed [apma_pkg::ACCEL_W-1:0] z
  );
    int                          mag_x;
    int                          mag_y;
    int                          mag_z;
    int                          peak;
    logic [apma_pkg::PEAK_W-1:0] oldest;
    window_result_t              res;
    mag_x = int'(x);
    mag_y = int'(y);
    mag_z = int'(z) - int'(offset_model);
    if (mag_x < 0) mag_x = -mag_x;
    if (mag_y < 0) mag_y = -mag_y;
    if (mag_z < 0) mag_z = -mag_z;
    peak = (mag_x > mag_y) ? mag_x : mag_y;
    if (mag_z > peak) peak = mag_z;

    oldest                = peak_store[next_slot];
    peak_store[next_slot] = apma_pkg::PEAK_W'(peak);
    running_sum           = running_sum - apma_pkg::SUM_W'(oldest)
                            + apma_pkg::SUM_W'(peak);
    next_slot             = (next_slot == WINDOW_LEN - 1) ? 0 : next_slot + 1;

    res.window_average = apma_pkg::AVG_W'(running_sum / WINDOW_LEN);
    res.sample_peak    = apma_pkg::PEAK_W'(peak);
    return res;
  endfunction

  // ------------------------------------------------------------------------
  // Channel monitor
  // ------------------------------------------------------------------------
  // Sample all three channels at the rising edge, before the block's own
  // registers move. Apply an offset write first, then queue the prediction
  // for an accepted sample, then check an accepted result.
  always @(posedge clk) begin
    window_result_t want;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready)
        offset_model = cfg_if.gravity_offset;

      if (in_if.valid && in_if.ready)
        pending_results.push_back(advance_window(in_if.accel_x, in_if.accel_y,
                                                 in_if.accel_z));

      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no sample outstanding: window_average %0d, sample_peak %0d",
                 out_if.window_average, out_if.sample_peak);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_if.window_average !== want.window_average) begin
            $error("window_average: expected %0d, actual %0d",
                   want.window_average, out_if.window_average);
            fail_count++;
          end
          if (out_if.sample_peak !== want.sample_peak) begin
            $error("sample_peak: expected %0d, actual %0d",
                   want.sample_peak, out_if.sample_peak);
            fail_count++;
          end
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Receiver: drop ready at random according to the current stall rate
  // ------------------------------------------------------------------------
  always @(negedge clk)
    out_if.ready = ($urandom_range(0, 99) >= recv_stall_pct);

  // ------------------------------------------------------------------------
  // Watchdog: count cycles with no transaction on any channel
  // ------------------------------------------------------------------------
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Shared driving tasks (all entered and left at a falling edge)
  // ------------------------------------------------------------------------
  // Hold off for a random gap, present the sample and hold it until the
  // block takes it.
  task automatic send_sample(input logic signed [apma_pkg::ACCEL_W-1:0] x,
                             input logic signed [apma_pkg::ACCEL_W-1:0] y,
                             input logic signed [apma_pkg::ACCEL_W-1:0] z);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid   = 1'b1;
    in_if.accel_x = x;
    in_if.accel_y = y;
    in_if.accel_z = z;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  // Drop the sample channel and wait until every queued result has arrived.
  task automatic drain_results();
    in_if.valid = 1'b0;
    while (pending_results.size() != 0)
      @(negedge clk);
  endtask

  // Write the offset only with the pipeline empty: drain, let the last
  // stages settle, then hold the write until it is taken.
  task automatic write_gravity_offset(input logic [apma_pkg::OFFSET_W-1:0] value);
    drain_results();
    repeat (PIPE_LATENCY) @(negedge clk);
    cfg_if.valid          = 1'b1;
    cfg_if.gravity_offset = value;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------
  function automatic logic signed [apma_pkg::ACCEL_W-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return 16'sd0;
      3:       return -16'sd1;
      default: return 16'sd1;
    endcase
  endfunction

  // Mostly full-range noise; some samples at the axis extremes and some
  // resting near the gravity offset on Z, the way a sensor at rest reads.
  task automatic send_random_sample();
    int                                  pick;
    int                                  near_z;
    logic signed [apma_pkg::ACCEL_W-1:0] x;
    logic signed [apma_pkg::ACCEL_W-1:0] y;
    logic signed [apma_pkg::ACCEL_W-1:0] z;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      x = apma_pkg::ACCEL_W'($urandom());
      y = apma_pkg::ACCEL_W'($urandom());
      z = apma_pkg::ACCEL_W'($urandom());
    end else if (pick < 80) begin
      x = pick_extreme();
      y = pick_extreme();
      z = pick_extreme();
    end else begin
      near_z = int'(offset_model) + $urandom_range(0, 400) - 200;
      if (near_z > 32767) near_z = 32767;
      x = apma_pkg::ACCEL_W'($urandom_range(0, 600) - 300);
      y = apma_pkg::ACCEL_W'($urandom_range(0, 600) - 300);
      z = apma_pkg::ACCEL_W'(near_z);
    end
    send_sample(x, y, z);
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  task automatic apply_reset();
    offset_model = apma_pkg::OFFSET_RESET;
    foreach (peak_store[i]) peak_store[i] = '0;
    next_slot   = 0;
    running_sum = '0;
    rst_n = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
  endtask

  // Axis extremes at the reset offset of one g; -32768 on X or Y gives a
  // peak of 32768. The window is still filling throughout.
  task automatic test_axis_extremes();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_sample(16'sd0, 16'sd0, 16'sd16384);
    send_sample(-16'sd32768, 16'sd0, 16'sd16384);
    send_sample(16'sd32767, 16'sd0, 16'sd16384);
    send_sample(16'sd0, -16'sd32768, 16'sd16384);
    send_sample(16'sd0, 16'sd32767, 16'sd16384);
    send_sample(16'sd0, 16'sd0, -16'sd32768);
    send_sample(16'sd0, 16'sd0, 16'sd32767);
    send_sample(-16'sd1, 16'sd1, 16'sd16383);
    send_sample(16'sd300, -16'sd300, 16'sd16684);
  endtask

  // Both ends of the offset register: all ones lets Z swing to 65535, zero
  // leaves Z as it is. Restore the reset value afterwards.
  task automatic test_offset_extremes();
    write_gravity_offset(apma_pkg::OFFSET_W'(32767));
    send_sample(16'sd0, 16'sd0, -16'sd32768);
    send_sample(16'sd0, 16'sd0, 16'sd32767);
    send_sample(-16'sd32768, 16'sd32767, -16'sd32768);
    write_gravity_offset(apma_pkg::OFFSET_W'(0));
    send_sample(16'sd0, 16'sd0, 16'sd32767);
    send_sample(16'sd0, 16'sd0, -16'sd32768);
    send_sample(-16'sd1, -16'sd1, -16'sd1);
    write_gravity_offset(apma_pkg::OFFSET_RESET);
  endtask

  // Fill the whole window with the largest peak, past the wrap point, so
  // the sum sits at its top and the average reads 65535; then flush it
  // back down with zero peaks.
  task automatic test_window_saturation();
    write_gravity_offset(apma_pkg::OFFSET_W'(32767));
    repeat (WINDOW_LEN + 10) send_sample(16'sd0, 16'sd0, -16'sd32768);
    repeat (WINDOW_LEN + 10) send_sample(16'sd0, 16'sd0, 16'sd32767);
  endtask

  // One phase of random samples with its own offset, idle and stall pattern.
  task automatic test_random_traffic(input int n_items,
                                     input logic [apma_pkg::OFFSET_W-1:0] offset,
                                     input int idle_pct,
                                     input int stall_pct);
    write_gravity_offset(offset);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n_items) send_random_sample();
  endtask

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------
  initial begin
    fail_count            = 0;
    send_idle_pct         = 0;
    recv_stall_pct        = 0;
    rst_n                 = 1'b0;
    in_if.valid           = 1'b0;
    in_if.accel_x         = '0;
    in_if.accel_y         = '0;
    in_if.accel_z         = '0;
    out_if.ready          = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.gravity_offset = '0;

    @(negedge clk);
    apply_reset();

    test_axis_extremes();
    test_offset_extremes();
    test_window_saturation();
    test_random_traffic(140, apma_pkg::OFFSET_RESET, 0, 0);
    test_random_traffic(130, apma_pkg::OFFSET_W'(0), 86, 0);
    test_random_traffic(130, apma_pkg::OFFSET_W'(32767), 0, 86);
    test_random_traffic(110, apma_pkg::OFFSET_W'($urandom_range(0, 32767)), 12, 12);

    // Hold until every result is in, then give the pipeline time to show
    // any stray result.
    drain_results();
    repeat (PIPE_LATENCY + 5) @(posedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

### sim.f
src/apma_pkg.sv
src/apma_ifs.sv
src/apma_peak.sv
src/apma_window.sv
src/accel_peak_moving_average.sv
tb/accel_peak_moving_average_tb.sv
